@@ hw/rtl/flmf_pkg.sv @@
// Shared widths, codes and defaults of the fuel level midrange filter.
`default_nettype none

package flmf_pkg;

   localparam int LEVEL_W     = 7;
   localparam int ADC_W       = 10;
   localparam int SCALE_W     = 8;
   localparam int INDEX_W     = 7;
   localparam int VALUE_W     = 24;
   localparam int PROD_W      = ADC_W + SCALE_W;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;

   localparam int WINDOW_DEPTH_DEF = 8;
   localparam int TABLE_DEPTH_DEF  = 70;

   localparam logic               ENABLE_RESET = 1'b1;
   localparam logic [SCALE_W-1:0] SCALE_RESET  = 8'd1;

   typedef enum logic {
      MODE_SAMPLE      = 1'b0,
      MODE_TABLE_WRITE = 1'b1
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MEASURE_ENABLE = 1'b0,
      CSR_ADC_SCALE      = 1'b1
   } csr_index_type;

endpackage

`default_nettype wire

@@ hw/rtl/flmf_table.sv @@
// Threshold table: single-port write, registered read, contents undefined until written.
`default_nettype none

module flmf_table #(
   parameter int TABLE_DEPTH = flmf_pkg::TABLE_DEPTH_DEF,
   parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [ADDR_W-1:0]           wr_addr,
   input  wire logic [flmf_pkg::VALUE_W-1:0] wr_data,
   input  wire logic                        rd_en,
   input  wire logic [ADDR_W-1:0]           rd_addr,
   output logic      [flmf_pkg::VALUE_W-1:0] rd_data
);

   logic [flmf_pkg::VALUE_W-1:0] mem [TABLE_DEPTH];
   logic [flmf_pkg::VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/flmf_window.sv @@
// Level window memory with per-entry valid bits; an entry never written reads as zero.
`default_nettype none

module flmf_window #(
   parameter int WINDOW_DEPTH = flmf_pkg::WINDOW_DEPTH_DEF,
   parameter int ADDR_W       = $clog2(WINDOW_DEPTH)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        wr_en,
   input  wire logic [ADDR_W-1:0]           wr_addr,
   input  wire logic [flmf_pkg::LEVEL_W-1:0] wr_data,
   input  wire logic                        rd_en,
   input  wire logic [ADDR_W-1:0]           rd_addr,
   output logic      [flmf_pkg::LEVEL_W-1:0] rd_data
);

   logic [flmf_pkg::LEVEL_W-1:0] mem [WINDOW_DEPTH];
   logic [WINDOW_DEPTH-1:0]      vld_ff;
   logic [flmf_pkg::LEVEL_W-1:0] rd_data_ff;
   logic                         rd_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_vld_ff  <= vld_ff[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

@@ hw/rtl/fuel_level_midrange_filter.sv @@
// Top level: sequencer for threshold search, window update and min/max scan.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  mode, adc_value, table_index, table_value
//   rsp_      out        rsp_valid / rsp_stall  fuel_level, newest_level, window_min/max
//   csr_      in         csr_write              csr_index, csr_wdata
//
// A sample passes through the search, window, scan and output states to its result:
// the threshold search reads the table memory one entry per cycle, the window scan
// reads the window memory one entry per cycle. Table writes and disabled samples
// stay idle. Reset clears the window valid bits, pointer and control registers, not data.
// A result waiting under rsp_stall blocks only the final output load.
`default_nettype none

module fuel_level_midrange_filter #(
   parameter int WINDOW_DEPTH = flmf_pkg::WINDOW_DEPTH_DEF,
   parameter int TABLE_DEPTH  = flmf_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_mode,
   input  wire logic [flmf_pkg::ADC_W-1:0]       req_adc_value,
   input  wire logic [flmf_pkg::INDEX_W-1:0]     req_table_index,
   input  wire logic [flmf_pkg::VALUE_W-1:0]     req_table_value,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [flmf_pkg::LEVEL_W-1:0]     rsp_fuel_level,
   output logic      [flmf_pkg::LEVEL_W-1:0]     rsp_newest_level,
   output logic      [flmf_pkg::LEVEL_W-1:0]     rsp_window_min,
   output logic      [flmf_pkg::LEVEL_W-1:0]     rsp_window_max,
   input  wire logic                            csr_write,
   input  wire logic [flmf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [flmf_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int TAW   = $clog2(TABLE_DEPTH);
   localparam int WAW   = $clog2(WINDOW_DEPTH);
   localparam int CNT_W = $clog2(((TABLE_DEPTH > WINDOW_DEPTH) ? TABLE_DEPTH : WINDOW_DEPTH) + 1);
   localparam int LW    = flmf_pkg::LEVEL_W;
   localparam int PW    = flmf_pkg::PROD_W;
   localparam int VW    = flmf_pkg::VALUE_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_WINDOW,
      ST_SCAN,
      ST_OUT
   } state_type;

   state_type                       state_ff, state_in;
   logic                            enable_ff, enable_in;
   logic [flmf_pkg::SCALE_W-1:0]    scale_ff, scale_in;
   logic [PW-1:0]                   product_ff, product_in;
   logic [CNT_W-1:0]                iss_ff, iss_in;
   logic [CNT_W-1:0]                chk_ff, chk_in;
   logic                            chk_vld_ff, chk_vld_in;
   logic [LW-1:0]                   level_ff, level_in;
   logic [WAW-1:0]                  wptr_ff, wptr_in;
   logic [LW-1:0]                   min_ff, min_in;
   logic [LW-1:0]                   max_ff, max_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [LW-1:0]                   rsp_fuel_ff, rsp_fuel_in;
   logic [LW-1:0]                   rsp_newest_ff, rsp_newest_in;
   logic [LW-1:0]                   rsp_min_ff, rsp_min_in;
   logic [LW-1:0]                   rsp_max_ff, rsp_max_in;

   logic                            req_accept;
   logic                            tbl_wr_en;
   logic                            tbl_rd_en;
   logic [VW-1:0]                   tbl_rd_data;
   logic                            win_wr_en;
   logic                            win_rd_en;
   logic [LW-1:0]                   win_rd_data;
   logic [WAW-1:0]                  wptr_next;
   logic [LW:0]                     mid_sum;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign tbl_wr_en  = req_accept && (req_mode == flmf_pkg::MODE_TABLE_WRITE)
                       && (req_table_index < flmf_pkg::INDEX_W'(TABLE_DEPTH));
   assign wptr_next  = (wptr_ff == WAW'(WINDOW_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
   assign mid_sum    = {1'b0, min_ff} + {1'b0, max_ff};

   flmf_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (req_table_index[TAW-1:0]),
      .wr_data (req_table_value),
      .rd_en   (tbl_rd_en),
      .rd_addr (iss_ff[TAW-1:0]),
      .rd_data (tbl_rd_data)
   );

   flmf_window #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (win_wr_en),
      .wr_addr (wptr_next),
      .wr_data (level_ff),
      .rd_en   (win_rd_en),
      .rd_addr (iss_ff[WAW-1:0]),
      .rd_data (win_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      enable_in     = enable_ff;
      scale_in      = scale_ff;
      product_in    = product_ff;
      iss_in        = iss_ff;
      chk_in        = chk_ff;
      chk_vld_in    = chk_vld_ff;
      level_in      = level_ff;
      wptr_in       = wptr_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_fuel_in   = rsp_fuel_ff;
      rsp_newest_in = rsp_newest_ff;
      rsp_min_in    = rsp_min_ff;
      rsp_max_in    = rsp_max_ff;
      tbl_rd_en     = 1'b0;
      win_wr_en     = 1'b0;
      win_rd_en     = 1'b0;

      if (csr_write) begin
         case (csr_index)
            flmf_pkg::CSR_MEASURE_ENABLE: enable_in = csr_wdata[0];
            flmf_pkg::CSR_ADC_SCALE:      scale_in  = csr_wdata[flmf_pkg::SCALE_W-1:0];
            default: ;
         endcase
      end

      // drop the result once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_mode == flmf_pkg::MODE_SAMPLE) && enable_ff) begin
               product_in = PW'(req_adc_value) * PW'(scale_ff);
               iss_in     = '0;
               chk_vld_in = 1'b0;
               state_in   = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            // issue the next read while the previous entry's data is compared
            tbl_rd_en  = (iss_ff < CNT_W'(TABLE_DEPTH));
            chk_in     = iss_ff;
            chk_vld_in = tbl_rd_en;
            if (tbl_rd_en) begin
               iss_in = iss_ff + 1'b1;
            end
            if (chk_vld_ff) begin
               if (VW'(product_ff) >= tbl_rd_data) begin
                  level_in = LW'(chk_ff);
                  state_in = ST_WINDOW;
               end else if (chk_ff == CNT_W'(TABLE_DEPTH - 1)) begin
                  level_in = LW'(TABLE_DEPTH);
                  state_in = ST_WINDOW;
               end
            end
         end
         ST_WINDOW: begin
            win_wr_en  = 1'b1;
            wptr_in    = wptr_next;
            iss_in     = '0;
            chk_vld_in = 1'b0;
            min_in     = '1;
            max_in     = '0;
            state_in   = ST_SCAN;
         end
         ST_SCAN: begin
            win_rd_en  = (iss_ff < CNT_W'(WINDOW_DEPTH));
            chk_in     = iss_ff;
            chk_vld_in = win_rd_en;
            if (win_rd_en) begin
               iss_in = iss_ff + 1'b1;
            end
            if (chk_vld_ff) begin
               if (win_rd_data < min_ff) begin
                  min_in = win_rd_data;
               end
               if (win_rd_data > max_ff) begin
                  max_in = win_rd_data;
               end
               if (chk_ff == CNT_W'(WINDOW_DEPTH - 1)) begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_fuel_in   = mid_sum[LW:1];
               rsp_newest_in = level_ff;
               rsp_min_in    = min_ff;
               rsp_max_in    = max_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         enable_ff    <= flmf_pkg::ENABLE_RESET;
         scale_ff     <= flmf_pkg::SCALE_RESET;
         wptr_ff      <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         scale_ff     <= scale_in;
         wptr_ff      <= wptr_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      product_ff    <= product_in;
      iss_ff        <= iss_in;
      chk_ff        <= chk_in;
      level_ff      <= level_in;
      min_ff        <= min_in;
      max_ff        <= max_in;
      rsp_fuel_ff   <= rsp_fuel_in;
      rsp_newest_ff <= rsp_newest_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_max_ff    <= rsp_max_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fuel_level   = rsp_fuel_ff;
   assign rsp_newest_level = rsp_newest_ff;
   assign rsp_window_min   = rsp_min_ff;
   assign rsp_window_max   = rsp_max_ff;

   a_mid_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_min_ff <= rsp_fuel_ff) && (rsp_fuel_ff <= rsp_max_ff))
      else $error("midrange outside window bounds");

   a_newest_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_min_ff <= rsp_newest_ff) && (rsp_newest_ff <= rsp_max_ff))
      else $error("newest level outside window bounds");

   a_out_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) && !rsp_stall |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("result not loaded on free output");

   a_window_then_scan: assert property (@(posedge clock) disable iff (reset)
      win_wr_en |=> (state_ff == ST_SCAN) && (wptr_ff == $past(wptr_next)))
      else $error("window write not followed by scan");

endmodule

`default_nettype wire
